FILE: rtl/greedy_nms_box_filter_top_macros.svh
// ----------------------------------------------------------------------------
// greedy nms box filter assertion macros
// shared concurrent checks, clocked on i_clk and disabled while i_rst_n is low
// ----------------------------------------------------------------------------
`ifndef GREEDY_NMS_BOX_FILTER_TOP_MACROS_SVH
`define GREEDY_NMS_BOX_FILTER_TOP_MACROS_SVH

// condition must never be true
`define GNMS_ASSERT_NEVER(label, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error("gnms invariant violated");

// antecedent implies consequent in the same cycle
`define GNMS_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("gnms same-cycle implication violated");

// antecedent implies consequent in the next cycle
`define GNMS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("gnms next-cycle implication violated");

`endif

FILE: rtl/gnms_pkg.sv
// ----------------------------------------------------------------------------
// gnms_pkg
// constants, widths and types shared by the greedy nms box filter
// ----------------------------------------------------------------------------
package gnms_pkg;

    // store depth and coordinate width
    localparam int MAX_KEPT   = 64;
    localparam int COORD_BITS = 16;

    // derived widths
    localparam int COUNT_W = $clog2(MAX_KEPT + 1);
    localparam int SPAN_W  = COORD_BITS + 1;
    localparam int AREA_W  = 2 * COORD_BITS;
    localparam int INTER_W = 2 * COORD_BITS;
    localparam int UNI_W   = AREA_W + 1;
    localparam int THR_W   = 9;
    localparam int PROD_W  = UNI_W + THR_W;
    localparam int SCALE_SHIFT = 8;
    localparam int TOTAL_W = 7;

    // threshold after reset, about 0.45 in units of 1/256
    localparam logic [THR_W-1:0] THR_RESET = THR_W'(115);

    typedef struct packed {
        logic [COORD_BITS-1:0] left;
        logic [COORD_BITS-1:0] top;
        logic [COORD_BITS-1:0] width;
        logic [COORD_BITS-1:0] height;
    } t_box;

    // one kept entry of the store
    typedef struct packed {
        t_box              box;
        logic [AREA_W-1:0] area;
    } t_entry;

    // candidate travelling down the cell chain
    typedef struct packed {
        logic              valid;
        logic              sup;
        t_box              box;
        logic [AREA_W-1:0] area;
    } t_token;

    // one result transaction
    typedef struct packed {
        logic               keep;
        logic               overflow;
        logic [TOTAL_W-1:0] kept_total;
    } t_result;

endpackage

FILE: rtl/gnms_box_if.sv
// ----------------------------------------------------------------------------
// gnms_box_if
// candidate box channel with valid/ready handshake
// ----------------------------------------------------------------------------
interface gnms_box_if;
    import gnms_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  frame_start;
    logic [COORD_BITS-1:0] box_left;
    logic [COORD_BITS-1:0] box_top;
    logic [COORD_BITS-1:0] box_width;
    logic [COORD_BITS-1:0] box_height;

    modport source (
        output valid, frame_start, box_left, box_top, box_width, box_height,
        input  ready
    );

    modport sink (
        input  valid, frame_start, box_left, box_top, box_width, box_height,
        output ready
    );
endinterface

FILE: rtl/gnms_res_if.sv
// ----------------------------------------------------------------------------
// gnms_res_if
// suppression result channel with valid/ready handshake
// ----------------------------------------------------------------------------
interface gnms_res_if;
    import gnms_pkg::*;

    logic               valid;
    logic               ready;
    logic               keep;
    logic               overflow;
    logic [TOTAL_W-1:0] kept_total;

    modport source (
        output valid, keep, overflow, kept_total,
        input  ready
    );

    modport sink (
        input  valid, keep, overflow, kept_total,
        output ready
    );
endinterface

FILE: rtl/greedy_nms_box_filter_top.sv
// ----------------------------------------------------------------------------
// greedy_nms_box_filter_top
// Greedy non-maximum suppression for score-sorted boxes of one frame.
// Boxes arrive on i_box, one result per box leaves on o_res. A box with
// frame_start set first empties the kept list. The box travels down a chain
// of MAX_KEPT cells, one cell per cycle, each cell testing it against the
// kept box it holds (inter*256 > threshold*union, union nonzero). At the end
// of the chain a surviving box is shifted into the first cell, or flagged
// overflow when the list is full.
// The accepted box is registered at the head, passes the cells and its result
// is registered on o_res; one box is in the chain at a time, so a new box is
// taken only after the last has left the chain. The user must write the
// threshold through i_cfg_we / i_cfg_wdata only while idle; it is unchecked.
// Reset empties the kept list, sets the threshold to 115 and drops results.
// A stalled receiver does not hold the chain: one result waits on o_res and
// a second in a skid register; i_box.ready is low while a box is in the
// chain or while the skid register is full.
// ----------------------------------------------------------------------------
`include "greedy_nms_box_filter_top_macros.svh"

module greedy_nms_box_filter_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [gnms_pkg::THR_W-1:0] i_cfg_wdata,
    gnms_box_if.sink                   i_box,
    gnms_res_if.source                 o_res
);
    import gnms_pkg::*;

    logic [THR_W-1:0]   r_thr;
    logic [COUNT_W-1:0] r_count;
    logic               r_busy;
    t_token             r_head;
    t_result            r_out;
    logic               r_out_valid;
    t_result            r_pend;
    logic               r_pend_valid;

    t_token             w_tok   [MAX_KEPT+1];
    t_entry             w_entry [MAX_KEPT];
    t_entry             w_shift [MAX_KEPT];
    logic [MAX_KEPT-1:0] w_occupied;

    logic               w_accept;
    logic               w_finish;
    logic               w_survive;
    logic               w_full;
    logic               w_keep;
    logic [COUNT_W-1:0] n_count;
    t_result            w_res;
    logic               w_out_fire;

    // input handshake
    assign i_box.ready = !r_busy && !r_pend_valid;
    assign w_accept    = i_box.valid && i_box.ready;

    // threshold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (i_cfg_we) begin
            r_thr <= i_cfg_wdata;
        end
    end

    // candidate entering the chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head.valid <= 1'b0;
            r_head.sup   <= 1'b0;
        end else begin
            r_head.valid <= w_accept;
            r_head.sup   <= 1'b0;
        end
        if (w_accept) begin
            r_head.box.left   <= i_box.box_left;
            r_head.box.top    <= i_box.box_top;
            r_head.box.width  <= i_box.box_width;
            r_head.box.height <= i_box.box_height;
            r_head.area       <= AREA_W'(i_box.box_width) * AREA_W'(i_box.box_height);
        end
    end

    assign w_tok[0] = r_head;

    // cell chain
    for (genvar j = 0; j < MAX_KEPT; j++) begin : g_cell
        assign w_occupied[j] = COUNT_W'(j) < r_count;

        if (j == 0) begin : g_first
            assign w_shift[j] = '{box: w_tok[MAX_KEPT].box, area: w_tok[MAX_KEPT].area};
        end else begin : g_rest
            assign w_shift[j] = w_entry[j-1];
        end

        gnms_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_thr      (r_thr),
            .i_occupied (w_occupied[j]),
            .i_tok      (w_tok[j]),
            .o_tok      (w_tok[j+1]),
            .i_load     (w_keep),
            .i_shift    (w_shift[j]),
            .o_entry    (w_entry[j])
        );
    end

    // decision at the end of the chain
    assign w_finish  = w_tok[MAX_KEPT].valid;
    assign w_survive = w_finish && !w_tok[MAX_KEPT].sup;
    assign w_full    = r_count == COUNT_W'(MAX_KEPT);
    assign w_keep    = w_survive && !w_full;
    assign n_count   = w_keep ? r_count + COUNT_W'(1) : r_count;

    always_comb begin
        w_res.keep       = w_keep;
        w_res.overflow   = w_survive && w_full;
        w_res.kept_total = TOTAL_W'(n_count);
    end

    // busy flag and kept count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_count <= '0;
        end else begin
            if (w_accept) begin
                r_busy <= 1'b1;
            end else if (w_finish) begin
                r_busy <= 1'b0;
            end
            if (w_accept && i_box.frame_start) begin
                r_count <= '0;
            end else if (w_finish) begin
                r_count <= n_count;
            end
        end
    end

    // output register and skid entry
    assign w_out_fire = r_out_valid && o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_pend_valid <= 1'b0;
        end else if (w_finish) begin
            if (!r_out_valid || w_out_fire) begin
                r_out_valid <= 1'b1;
            end else begin
                r_pend_valid <= 1'b1;
            end
        end else if (w_out_fire) begin
            if (r_pend_valid) begin
                r_pend_valid <= 1'b0;
            end else begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_finish) begin
            if (!r_out_valid || w_out_fire) begin
                r_out <= w_res;
            end else begin
                r_pend <= w_res;
            end
        end else if (w_out_fire && r_pend_valid) begin
            r_out <= r_pend;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.keep       = r_out.keep;
    assign o_res.overflow   = r_out.overflow;
    assign o_res.kept_total = r_out.kept_total;

    // checks
    `GNMS_ASSERT_NEVER(a_busy_with_pend, r_busy && r_pend_valid)
    `GNMS_ASSERT_IMPL(a_finish_when_busy, w_finish, r_busy)
    `GNMS_ASSERT_NEVER(a_count_bound, r_count > COUNT_W'(MAX_KEPT))
    `GNMS_ASSERT_IMPL(a_pend_needs_out, r_pend_valid, r_out_valid)
    `GNMS_ASSERT_NEXT(a_keep_counts, w_keep, r_count == $past(r_count) + COUNT_W'(1))
endmodule

FILE: rtl/gnms_cell.sv
// ----------------------------------------------------------------------------
// gnms_cell
// one kept-box slot: holds an entry, registers the overlap of the passing
// candidate with it, then runs the ratio test and hands it to the next cell
// ----------------------------------------------------------------------------
module gnms_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [gnms_pkg::THR_W-1:0]  i_thr,
    input  logic                        i_occupied,
    input  gnms_pkg::t_token            i_tok,
    output gnms_pkg::t_token            o_tok,
    input  logic                        i_load,
    input  gnms_pkg::t_entry            i_shift,
    output gnms_pkg::t_entry            o_entry
);
    import gnms_pkg::*;

    t_entry             r_entry;
    t_token             r_tok;
    logic               r_chk;
    logic [INTER_W-1:0] r_inter;

    logic [SPAN_W-1:0]     w_cand_right;
    logic [SPAN_W-1:0]     w_cand_bottom;
    logic [SPAN_W-1:0]     w_kept_right;
    logic [SPAN_W-1:0]     w_kept_bottom;
    logic [SPAN_W-1:0]     w_x_lo;
    logic [SPAN_W-1:0]     w_x_hi;
    logic [SPAN_W-1:0]     w_y_lo;
    logic [SPAN_W-1:0]     w_y_hi;
    logic [COORD_BITS-1:0] w_iw;
    logic [COORD_BITS-1:0] w_ih;
    logic [INTER_W-1:0]    n_inter;
    logic [UNI_W-1:0]      w_uni;
    logic [PROD_W-1:0]     w_prod;
    logic [PROD_W-1:0]     w_scaled;
    logic                  w_hit;

    // stored entry, shifted in from the neighbor when a box is kept
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_entry <= i_shift;
        end
    end

    assign o_entry = r_entry;

    // edges of both boxes, no wrap
    assign w_cand_right  = SPAN_W'(i_tok.box.left) + SPAN_W'(i_tok.box.width);
    assign w_cand_bottom = SPAN_W'(i_tok.box.top) + SPAN_W'(i_tok.box.height);
    assign w_kept_right  = SPAN_W'(r_entry.box.left) + SPAN_W'(r_entry.box.width);
    assign w_kept_bottom = SPAN_W'(r_entry.box.top) + SPAN_W'(r_entry.box.height);

    // overlap spans along each axis
    always_comb begin
        w_x_lo = (i_tok.box.left > r_entry.box.left) ? SPAN_W'(i_tok.box.left)
                                                     : SPAN_W'(r_entry.box.left);
        w_x_hi = (w_cand_right < w_kept_right) ? w_cand_right : w_kept_right;
        w_y_lo = (i_tok.box.top > r_entry.box.top) ? SPAN_W'(i_tok.box.top)
                                                   : SPAN_W'(r_entry.box.top);
        w_y_hi = (w_cand_bottom < w_kept_bottom) ? w_cand_bottom : w_kept_bottom;
        w_iw   = (w_x_hi > w_x_lo) ? COORD_BITS'(w_x_hi - w_x_lo) : '0;
        w_ih   = (w_y_hi > w_y_lo) ? COORD_BITS'(w_y_hi - w_y_lo) : '0;
    end

    // intersection area
    assign n_inter = INTER_W'(w_iw) * INTER_W'(w_ih);

    // first stage registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
            r_tok.sup   <= 1'b0;
            r_chk       <= 1'b0;
        end else begin
            r_tok <= i_tok;
            r_chk <= i_tok.valid & i_occupied;
        end
        r_inter <= n_inter;
    end

    // second stage: cross-multiplied ratio test
    assign w_uni    = UNI_W'(r_tok.area) + UNI_W'(r_entry.area) - UNI_W'(r_inter);
    assign w_prod   = PROD_W'(i_thr) * PROD_W'(w_uni);
    assign w_scaled = PROD_W'(r_inter) << SCALE_SHIFT;
    assign w_hit    = r_chk && (w_uni != '0) && (w_scaled > w_prod);

    // hand the candidate on with the suppress flag merged
    always_comb begin
        o_tok     = r_tok;
        o_tok.sup = r_tok.sup | w_hit;
    end
endmodule
